// ----- sv/superposition_score_accumulator_defines.svh -----
// assertion macros shared by the score accumulator rtl
`ifndef SUPERPOSITION_SCORE_ACCUMULATOR_DEFINES_SVH
`define SUPERPOSITION_SCORE_ACCUMULATOR_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define SSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("score accumulator same-cycle check failed");

// consequence must hold in the cycle after the antecedent
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("score accumulator next-cycle check failed");

`endif

// ----- sv/ssa_pkg.sv -----
// types and constants of the score accumulator
`default_nettype none

package ssa_pkg;

	// field widths
	localparam int D0_W       = 29;
	localparam int LEN_W      = 13;
	localparam int CUT_W      = 40;
	localparam int CFG_W      = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CLS_W      = 2;
	localparam int PD_W       = 50;
	localparam int CNT_W      = 13;
	localparam int RMSD_W     = 24;
	localparam int TM_W       = 17;
	localparam int STAT_W     = 2;

	// accumulator and datapath widths
	localparam int SQ_SUM_W    = 62;
	localparam int TM_SUM_W    = 29;
	localparam int MAG_W       = 33;
	localparam int SQ_MAG_BITS = 31;
	localparam int PROD_W      = 63;
	localparam int D2_W        = 64;
	localparam int DIV_W       = 64;
	localparam int DVD_W       = 62;
	localparam int STEP_W      = 6;
	localparam int SQRT_W      = 63;
	localparam int SQRT_K_W    = 5;
	localparam int ROOT_W      = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_D0_SQ      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_CLOSE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_NEAR   = 2'd3;

	// register reset values
	localparam logic [D0_W-1:0]  D0_RESET        = 29'd26214400;
	localparam logic [LEN_W-1:0] LEN_RESET       = 13'd100;
	localparam logic [CUT_W-1:0] CUT_CLOSE_RESET = 40'd9437184;
	localparam logic [CUT_W-1:0] CUT_NEAR_RESET  = 40'd26214400;

	// pair classes
	localparam logic [CLS_W-1:0] CLS_CLOSE     = 2'd0;
	localparam logic [CLS_W-1:0] CLS_NEAR      = 2'd1;
	localparam logic [CLS_W-1:0] CLS_FAR       = 2'd2;
	localparam logic [CLS_W-1:0] CLS_UNALIGNED = 2'd3;

	// summary status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_PAIRS = 2'd1;
	localparam logic [STAT_W-1:0] ST_SHORT    = 2'd2;

	// limits
	localparam logic [LEN_W-1:0]    SHORT_TARGET = 13'd15;
	localparam logic [TM_W-1:0]     TM_ONE       = 17'd65536;
	localparam logic [CNT_W-1:0]    COUNT_MAX    = '1;
	localparam logic [SQ_SUM_W-1:0] SQ_SUM_MAX   = '1;
	localparam logic [TM_SUM_W-1:0] TM_SUM_MAX   = '1;
	localparam logic [PD_W-1:0]     PD_MAX       = '1;
	localparam logic [RMSD_W-1:0]   RMSD_MAX     = '1;
	localparam logic [PROD_W-1:0]   SQ_SAT       = {1'b1, {(PROD_W-1){1'b0}}};

	// divider step counts
	localparam logic [STEP_W-1:0] STEPS_TERM = 6'd17;
	localparam logic [STEP_W-1:0] STEPS_MEAN = 6'd62;
	localparam logic [STEP_W-1:0] STEPS_TM   = 6'd29;

	// root unit first bit pair index
	localparam logic [SQRT_K_W-1:0] SQRT_K_TOP = 5'd31;

	// request to the shared divider
	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    rem_init;
		logic [DVD_W-1:0]    dividend;
		logic [DIV_W-1:0]    divisor;
		logic [STEP_W-1:0]   steps;
	} div_req_t;

	// status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

// ----- sv/ssa_if.sv -----
// valid/ready channels of the score accumulator
`default_nettype none

interface ssa_in_if #(parameter int COORD_WIDTH = 24);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] subj_x;
	logic signed [COORD_WIDTH-1:0] subj_y;
	logic signed [COORD_WIDTH-1:0] subj_z;
	logic signed [COORD_WIDTH-1:0] partner_x;
	logic signed [COORD_WIDTH-1:0] partner_y;
	logic signed [COORD_WIDTH-1:0] partner_z;
	logic                          is_aligned;
	logic                          last_residue;

	modport source (
		output valid, subj_x, subj_y, subj_z, partner_x, partner_y, partner_z,
		output is_aligned, last_residue,
		input  ready
	);
	modport sink (
		input  valid, subj_x, subj_y, subj_z, partner_x, partner_y, partner_z,
		input  is_aligned, last_residue,
		output ready
	);
endinterface

interface ssa_out_if;
	import ssa_pkg::*;
	logic                valid;
	logic                ready;
	logic [CLS_W-1:0]    pair_class;
	logic [PD_W-1:0]     pair_sq_distance;
	logic                is_summary;
	logic [CNT_W-1:0]    aligned_count;
	logic [RMSD_W-1:0]   rmsd_value;
	logic [TM_W-1:0]     tm_value;
	logic [STAT_W-1:0]   score_status;

	modport source (
		output valid, pair_class, pair_sq_distance, is_summary, aligned_count,
		output rmsd_value, tm_value, score_status,
		input  ready
	);
	modport sink (
		input  valid, pair_class, pair_sq_distance, is_summary, aligned_count,
		input  rmsd_value, tm_value, score_status,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/ssa_div.sv -----
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module ssa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssa_pkg::div_req_t             req,
	output ssa_pkg::unit_stat_t           stat,
	output logic [ssa_pkg::DVD_W-1:0]     quotient
);
	import ssa_pkg::*;

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [STEP_W-1:0] steps_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              fits;

	// partial remainder with next dividend bit, trial subtract
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = !diff[DIV_W];

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				steps_q <= req.steps;
			end else if (steps_q != '0) begin
				steps_q <= steps_q - STEP_W'(1);
				done_q  <= (steps_q == STEP_W'(1));
			end
		end
	end

	// remainder, dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.rem_init;
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
			quo_q     <= '0;
		end else if (steps_q != '0) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign stat.busy = (steps_q != '0);
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// ----- sv/ssa_sqrt.sv -----
// integer square root, one result bit per cycle
`default_nettype none

module ssa_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ssa_pkg::DVD_W-1:0]     value,
	output ssa_pkg::unit_stat_t           stat,
	output logic [ssa_pkg::ROOT_W-1:0]    root
);
	import ssa_pkg::*;

	logic [SQRT_W-1:0]   v_q;
	logic [SQRT_W-1:0]   res_q;
	logic [SQRT_K_W-1:0] k_q;
	logic                run_q;
	logic                done_q;
	logic [SQRT_W-1:0]   bit_v;
	logic [SQRT_W-1:0]   trial;
	logic                ge;

	// current bit pair and trial value
	assign bit_v = SQRT_W'(1) << {k_q, 1'b0};
	assign trial = res_q + bit_v;
	assign ge    = (v_q >= trial);

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				k_q   <= SQRT_K_TOP;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (k_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - SQRT_K_W'(1);
				end
			end
		end
	end

	// remainder and root registers
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= {1'b0, value};
			res_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_v;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign root      = res_q[ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- sv/superposition_score_accumulator.sv -----
// top level: tm-score and rmsd accumulation over a superposed chain
//
// item channel: one subject residue per word, its partner's superposed
// coordinates, an aligned flag and a last-residue flag. ready is high only
// while the sequencer is idle; one word is worked on at a time.
// result channel: one word per item, held in an output register. the next
// item is taken while that word still waits; a finished item waits in its
// output step until the register is free.
// steps: an unaligned residue that is not last goes straight to its output
// step. an aligned residue goes through the shared squarer, then the shared
// divider for the tm term. the last residue adds the mean on the divider,
// the root and the tm normalization on the divider.
// ready returns the cycle after the word is loaded into the output register.
// configuration: plain write port, indexes 0..3 for d0 squared, target length and
// the two squared cutoffs; the user must write them only while idle, the block does not enforce it.
// reset: registers go to their reset values, accumulators clear, no word
// is pending. accumulators clear again after each summary word.
`default_nettype none
`include "superposition_score_accumulator_defines.svh"

module superposition_score_accumulator #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssa_pkg::CFG_W-1:0]         cfg_data,
	ssa_in_if.sink                            item,
	ssa_out_if.source                         result
);
	import ssa_pkg::*;

	localparam int DIFF_W = COORD_WIDTH + 1;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_SQ      = 11'b000_0000_0010,
		S_TERM_GO = 11'b000_0000_0100,
		S_TERM_W  = 11'b000_0000_1000,
		S_MEAN_GO = 11'b000_0001_0000,
		S_MEAN_W  = 11'b000_0010_0000,
		S_ROOT_GO = 11'b000_0100_0000,
		S_ROOT_W  = 11'b000_1000_0000,
		S_TM_GO   = 11'b001_0000_0000,
		S_TM_W    = 11'b010_0000_0000,
		S_OUT     = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [D0_W-1:0]  d0_q;
	logic [LEN_W-1:0] len_q;
	logic [CUT_W-1:0] cut_close_q;
	logic [CUT_W-1:0] cut_near_q;

	// accumulators
	logic [SQ_SUM_W-1:0] sq_sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TM_SUM_W-1:0] tm_sum_q;

	// per item registers
	logic                     last_q;
	logic [1:0]               sq_idx_q;
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic signed [DIFF_W-1:0] dz_q;
	logic [PROD_W-1:0]        prod_q;
	logic [D2_W-1:0]          d2_q;
	logic [CLS_W-1:0]         cls_q;
	logic [PD_W-1:0]          pd_q;
	logic [RMSD_W-1:0]        rms_q;
	logic [TM_W-1:0]          tm_q;

	// output register
	logic                res_valid_q;
	logic [CLS_W-1:0]    res_cls_q;
	logic [PD_W-1:0]     res_pd_q;
	logic                res_sum_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic [RMSD_W-1:0]   res_rms_q;
	logic [TM_W-1:0]     res_tm_q;
	logic [STAT_W-1:0]   res_stat_q;

	// combinational datapath
	logic signed [DIFF_W-1:0]   dsel;
	logic [DIFF_W-1:0]          mag;
	logic [MAG_W-1:0]           mag_ext;
	logic                       sq_sat;
	logic [SQ_MAG_BITS-1:0]     mag_lo;
	logic [2*SQ_MAG_BITS-1:0]   sq_raw;
	logic [PROD_W-1:0]          sq_val;
	logic [CUT_W-1:0]           cut_lo;
	logic [CUT_W-1:0]           cut_hi;
	logic [D0_W-1:0]            d0_eff;
	logic [D2_W-1:0]            sq_sum_add;
	logic [TM_SUM_W:0]          tm_add;
	logic                       short_target;
	logic                       out_load;
	logic [CLS_W-1:0]           cls_next;
	logic [STAT_W-1:0]          stat_next;
	logic                       acc_zero;
	logic                       plain_totals_zero;

	div_req_t            div_req;
	unit_stat_t          div_stat;
	logic [DVD_W-1:0]    div_quo;
	logic                sqrt_start;
	unit_stat_t          sqrt_stat;
	logic [ROOT_W-1:0]   sqrt_root;

	// component select and magnitude
	always_comb begin
		case (sq_idx_q)
			2'd0:    dsel = dx_q;
			2'd1:    dsel = dy_q;
			default: dsel = dz_q;
		endcase
	end

	assign mag     = dsel[DIFF_W-1] ? DIFF_W'(-dsel) : DIFF_W'(dsel);
	assign mag_ext = MAG_W'(mag);
	assign sq_sat  = |mag_ext[MAG_W-1:SQ_MAG_BITS];
	assign mag_lo  = mag_ext[SQ_MAG_BITS-1:0];
	assign sq_raw  = {{SQ_MAG_BITS{1'b0}}, mag_lo} * {{SQ_MAG_BITS{1'b0}}, mag_lo};
	assign sq_val  = sq_sat ? SQ_SAT : PROD_W'(sq_raw);

	// cutoff ordering and classification
	assign cut_lo   = (cut_close_q > cut_near_q) ? cut_near_q : cut_close_q;
	assign cut_hi   = (cut_close_q > cut_near_q) ? cut_close_q : cut_near_q;
	assign cls_next = (d2_q < D2_W'(cut_lo)) ? CLS_CLOSE :
	                  (d2_q < D2_W'(cut_hi)) ? CLS_NEAR : CLS_FAR;

	// saturating accumulator sums
	assign d0_eff       = (d0_q == '0) ? D0_W'(1) : d0_q;
	assign sq_sum_add   = D2_W'(sq_sum_q) + d2_q;
	assign tm_add       = {1'b0, tm_sum_q} + (TM_SUM_W+1)'(div_quo[TM_W-1:0]);
	assign short_target = (len_q < SHORT_TARGET);

	// summary status
	assign stat_next = (cnt_q == '0) ? ST_NO_PAIRS :
	                   short_target  ? ST_SHORT : ST_OK;

	assign out_load = (state_q == S_OUT) && (!res_valid_q || result.ready);

	// divider requests per step
	always_comb begin
		div_req = '0;
		case (state_q)
			S_TERM_GO: begin
				div_req.start    = 1'b1;
				div_req.rem_init = DIV_W'(d0_eff >> 1);
				div_req.dividend = {d0_eff[0], {(DVD_W-1){1'b0}}};
				div_req.divisor  = DIV_W'(d0_eff) + d2_q;
				div_req.steps    = STEPS_TERM;
			end
			S_MEAN_GO: begin
				div_req.start    = (cnt_q != '0);
				div_req.dividend = sq_sum_q;
				div_req.divisor  = DIV_W'(cnt_q);
				div_req.steps    = STEPS_MEAN;
			end
			S_TM_GO: begin
				div_req.start    = !short_target;
				div_req.dividend = {tm_sum_q, {(DVD_W-TM_SUM_W){1'b0}}};
				div_req.divisor  = DIV_W'(len_q);
				div_req.steps    = STEPS_TM;
			end
			default: begin
			end
		endcase
	end

	assign sqrt_start = (state_q == S_ROOT_GO);

	ssa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	ssa_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (div_quo),
		.stat   (sqrt_stat),
		.root   (sqrt_root)
	);

	// sequencer, configuration and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			d0_q        <= D0_RESET;
			len_q       <= LEN_RESET;
			cut_close_q <= CUT_CLOSE_RESET;
			cut_near_q  <= CUT_NEAR_RESET;
			sq_sum_q    <= '0;
			cnt_q       <= '0;
			tm_sum_q    <= '0;
			last_q      <= 1'b0;
			sq_idx_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_D0_SQ:      d0_q        <= cfg_data[D0_W-1:0];
					REG_TARGET_LEN: len_q       <= cfg_data[LEN_W-1:0];
					REG_CUT_CLOSE:  cut_close_q <= cfg_data[CUT_W-1:0];
					REG_CUT_NEAR:   cut_near_q  <= cfg_data[CUT_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						last_q   <= item.last_residue;
						sq_idx_q <= '0;
						if (item.is_aligned) begin
							state_q <= S_SQ;
						end else if (item.last_residue) begin
							state_q <= S_MEAN_GO;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SQ: begin
					sq_idx_q <= sq_idx_q + 2'd1;
					if (sq_idx_q == 2'd3) begin
						state_q <= S_TERM_GO;
					end
				end
				S_TERM_GO: begin
					sq_sum_q <= (sq_sum_add[D2_W-1:SQ_SUM_W] != '0) ? SQ_SUM_MAX
					            : sq_sum_add[SQ_SUM_W-1:0];
					state_q  <= S_TERM_W;
				end
				S_TERM_W: begin
					if (div_stat.done) begin
						tm_sum_q <= tm_add[TM_SUM_W] ? TM_SUM_MAX : tm_add[TM_SUM_W-1:0];
						if (cnt_q != COUNT_MAX) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= last_q ? S_MEAN_GO : S_OUT;
					end
				end
				S_MEAN_GO: begin
					state_q <= (cnt_q != '0) ? S_MEAN_W : S_TM_GO;
				end
				S_MEAN_W: begin
					if (div_stat.done) begin
						state_q <= S_ROOT_GO;
					end
				end
				S_ROOT_GO: begin
					state_q <= S_ROOT_W;
				end
				S_ROOT_W: begin
					if (sqrt_stat.done) begin
						state_q <= S_TM_GO;
					end
				end
				S_TM_GO: begin
					state_q <= short_target ? S_OUT : S_TM_W;
				end
				S_TM_W: begin
					if (div_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (last_q) begin
							sq_sum_q <= '0;
							cnt_q    <= '0;
							tm_sum_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per item datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item.valid) begin
			dx_q  <= DIFF_W'(item.subj_x) - DIFF_W'(item.partner_x);
			dy_q  <= DIFF_W'(item.subj_y) - DIFF_W'(item.partner_y);
			dz_q  <= DIFF_W'(item.subj_z) - DIFF_W'(item.partner_z);
			d2_q  <= '0;
			cls_q <= CLS_UNALIGNED;
			pd_q  <= '0;
			rms_q <= '0;
			tm_q  <= '0;
		end

		// squarer feeds the adder in the next cycle, through prod_q
		if (state_q == S_SQ) begin
			if (sq_idx_q != 2'd3) begin
				prod_q <= sq_val;
			end
			if (sq_idx_q != 2'd0) begin
				d2_q <= d2_q + D2_W'(prod_q);
			end
		end

		if (state_q == S_TERM_GO) begin
			cls_q <= cls_next;
			pd_q  <= (d2_q > D2_W'(PD_MAX)) ? PD_MAX : d2_q[PD_W-1:0];
		end

		if ((state_q == S_ROOT_W) && sqrt_stat.done) begin
			rms_q <= (sqrt_root > ROOT_W'(RMSD_MAX)) ? RMSD_MAX : sqrt_root[RMSD_W-1:0];
		end

		if ((state_q == S_TM_W) && div_stat.done) begin
			tm_q <= (div_quo > DVD_W'(TM_ONE)) ? TM_ONE : div_quo[TM_W-1:0];
		end

		// output word
		if (out_load) begin
			res_cls_q  <= cls_q;
			res_pd_q   <= pd_q;
			res_sum_q  <= last_q;
			res_cnt_q  <= last_q ? cnt_q : '0;
			res_rms_q  <= rms_q;
			res_tm_q   <= tm_q;
			res_stat_q <= last_q ? stat_next : ST_OK;
		end
	end

	assign item.ready = (state_q == S_IDLE);

	assign result.valid            = res_valid_q;
	assign result.pair_class       = res_cls_q;
	assign result.pair_sq_distance = res_pd_q;
	assign result.is_summary       = res_sum_q;
	assign result.aligned_count    = res_cnt_q;
	assign result.rmsd_value       = res_rms_q;
	assign result.tm_value         = res_tm_q;
	assign result.score_status     = res_stat_q;

	// terms for the checks
	assign acc_zero          = (cnt_q == '0) && (sq_sum_q == '0) && (tm_sum_q == '0);
	assign plain_totals_zero = (result.aligned_count == '0) && (result.score_status == ST_OK);

	// checks
	`SSA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item.valid && item.ready, !item.ready)
	`SSA_ASSERT_SAME(a_div_start_free, clk, arst_n, div_req.start, !div_stat.busy)
	`SSA_ASSERT_NEXT(a_clear_after_summary, clk, arst_n, out_load && last_q, acc_zero)
	`SSA_ASSERT_SAME(a_tm_bound, clk, arst_n, result.valid, result.tm_value <= TM_ONE)
	`SSA_ASSERT_SAME(a_plain_word_totals, clk, arst_n, result.valid && !result.is_summary, plain_totals_zero)

endmodule

`default_nettype wire

// ----- sim/tb_superposition_score_accumulator.sv -----
// self-checking bench for the superposition score accumulator: directed plan, then random chains
`timescale 1ns / 100ps

module tb_superposition_score_accumulator;
	import ssa_pkg::*;

	localparam int CW = 24;
	localparam int LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 100;
	localparam logic [LEN_W-1:0] LEN_MAX = 13'd4096;
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COORD_MAX = ~COORD_MIN;

	// one subject residue as it goes over the item channel
	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] sz;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] pz;
		logic                 aligned;
		logic                 last;
	} residue_t;

	// one score word as it comes back
	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [PD_W-1:0]   dist_sq;
		logic              summary;
		logic [CNT_W-1:0]  count;
		logic [RMSD_W-1:0] rmsd;
		logic [TM_W-1:0]   tm;
		logic [STAT_W-1:0] status;
	} score_word_t;

	typedef enum logic {ROW_REG, ROW_RESIDUE} row_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} stall_mode_t;

	// one step of the directed plan
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_W-1:0]      reg_val;
		residue_t              res;
		logic                  typed;
		score_word_t           want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ssa_in_if #(.COORD_WIDTH(CW)) residue_bus ();
	ssa_out_if score_bus ();

	superposition_score_accumulator #(.COORD_WIDTH(CW)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (residue_bus),
		.result    (score_bus)
	);

	// shadow registers and accumulators of the score model
	logic [D0_W-1:0]     d0_sq = D0_RESET;
	logic [LEN_W-1:0]    tgt_len = LEN_RESET;
	logic [CUT_W-1:0]    cut_close = CUT_CLOSE_RESET;
	logic [CUT_W-1:0]    cut_near = CUT_NEAR_RESET;
	logic [SQ_SUM_W-1:0] sq_acc = '0;
	logic [CNT_W-1:0]    pairs_seen = '0;
	logic [TM_SUM_W-1:0] tm_acc = '0;

	score_word_t expected_scores[$];
	plan_row_t plan[$];
	int mismatches = 0;
	int burst_left = 0;
	int stall_left = 0;
	stall_mode_t stall_mode = RX_OPEN;
	int cycle_count;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// squared difference along one axis, held at 2^62 when the magnitude is too big
	function automatic longint unsigned axis_sq(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		longint diff;
		longint unsigned mag;
		diff = a - b;
		mag = (diff < 0) ? -diff : diff;
		if (mag >= (64'd1 << 31))
			return 64'd1 << 62;
		return mag * mag;
	endfunction

	// integer square root, one result bit at a time
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// score one residue: classify, accumulate, and close the chain on the last one
	function automatic score_word_t score_residue(input residue_t r);
		score_word_t w;
		longint unsigned d2, lo, hi, d0e, term, root, quot;
		w = '0;
		w.cls = CLS_UNALIGNED;
		if (r.aligned) begin
			d2 = axis_sq(r.sx, r.px) + axis_sq(r.sy, r.py) + axis_sq(r.sz, r.pz);
			lo = cut_close;
			hi = cut_near;
			if (lo > hi) begin
				lo = cut_near;
				hi = cut_close;
			end
			if (d2 < lo)
				w.cls = CLS_CLOSE;
			else if (d2 < hi)
				w.cls = CLS_NEAR;
			else
				w.cls = CLS_FAR;
			w.dist_sq = (d2 > PD_MAX) ? PD_MAX : d2;
			d0e = d0_sq;
			if (d0e == 0)
				d0e = 1;
			term = (d0e << 16) / (d0e + d2);
			sq_acc = (d2 > SQ_SUM_MAX - sq_acc) ? SQ_SUM_MAX : sq_acc + d2;
			tm_acc = (term > TM_SUM_MAX - tm_acc) ? TM_SUM_MAX : tm_acc + term;
			if (pairs_seen != COUNT_MAX)
				pairs_seen = pairs_seen + 1'b1;
		end
		if (r.last) begin
			w.summary = 1'b1;
			w.count = pairs_seen;
			if (pairs_seen != 0) begin
				root = floor_sqrt(sq_acc / pairs_seen);
				w.rmsd = (root > RMSD_MAX) ? RMSD_MAX : root;
			end
			if (tgt_len >= SHORT_TARGET) begin
				quot = tm_acc / tgt_len;
				w.tm = (quot > TM_ONE) ? TM_ONE : quot;
			end
			if (pairs_seen == 0)
				w.status = ST_NO_PAIRS;
			else if (tgt_len < SHORT_TARGET)
				w.status = ST_SHORT;
			else
				w.status = ST_OK;
			sq_acc = '0;
			pairs_seen = '0;
			tm_acc = '0;
		end
		return w;
	endfunction

	function automatic score_word_t word_of(input logic [CLS_W-1:0] cls,
		input logic [PD_W-1:0] dist_sq, input logic summary, input logic [CNT_W-1:0] count,
		input logic [RMSD_W-1:0] rmsd, input logic [TM_W-1:0] tm,
		input logic [STAT_W-1:0] status);
		score_word_t w;
		w.cls = cls;
		w.dist_sq = dist_sq;
		w.summary = summary;
		w.count = count;
		w.rmsd = rmsd;
		w.tm = tm;
		w.status = status;
		return w;
	endfunction

	function automatic plan_row_t residue_row(input logic signed [CW-1:0] sx,
		input logic signed [CW-1:0] sy, input logic signed [CW-1:0] sz,
		input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
		input logic signed [CW-1:0] pz, input logic aligned, input logic last,
		input logic typed, input score_word_t want);
		plan_row_t row;
		row = '0;
		row.kind = ROW_RESIDUE;
		row.res.sx = sx;
		row.res.sy = sy;
		row.res.sz = sz;
		row.res.px = px;
		row.res.py = py;
		row.res.pz = pz;
		row.res.aligned = aligned;
		row.res.last = last;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] val);
		plan_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// append one step to the directed plan
	function automatic void add_row(input plan_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	// random squared cutoff: extremes, the reset value or a value of random size
	function automatic logic [CUT_W-1:0] pick_cut();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return CUT_CLOSE_RESET;
			default: return {$urandom, $urandom} >> $urandom_range(24, 63);
		endcase
	endfunction

	// register write, shadowed in the score model
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_D0_SQ: d0_sq = val;
			REG_TARGET_LEN: tgt_len = val;
			REG_CUT_CLOSE: cut_close = val;
			REG_CUT_NEAR: cut_near = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// hold the item channel and wait for every score word to come back
	task automatic drain_results(input int settle);
		residue_bus.valid <= 1'b0;
		while (expected_scores.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// send one residue word in bursts with random gaps, then queue its score
	task automatic deliver(input residue_t r, input logic typed, input score_word_t want);
		score_word_t predicted;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				residue_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		residue_bus.valid <= 1'b1;
		residue_bus.subj_x <= r.sx;
		residue_bus.subj_y <= r.sy;
		residue_bus.subj_z <= r.sz;
		residue_bus.partner_x <= r.px;
		residue_bus.partner_y <= r.py;
		residue_bus.partner_z <= r.pz;
		residue_bus.is_aligned <= r.aligned;
		residue_bus.last_residue <= r.last;
		do @(posedge clk); while (!residue_bus.ready);
		burst_left--;
		predicted = score_residue(r);
		expected_scores.insert(expected_scores.size(), typed ? want : predicted);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result stall pattern: runs of open, random, periodic and mostly stalled
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(4, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			RX_OPEN: score_bus.ready <= 1'b1;
			RX_RANDOM: score_bus.ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: score_bus.ready <= (stall_left % 3 != 0);
			default: score_bus.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// compare each score word with the oldest expectation
	always @(posedge clk) begin : score_check
		score_word_t want;
		if (arst_n && score_bus.valid && score_bus.ready) begin
			if (expected_scores.size() == 0) begin
				$error("score word with no expectation waiting");
				mismatches++;
			end else begin
				want = expected_scores.pop_front();
				check_field("pair_class", want.cls, score_bus.pair_class);
				check_field("pair_sq_distance", want.dist_sq, score_bus.pair_sq_distance);
				check_field("is_summary", want.summary, score_bus.is_summary);
				check_field("aligned_count", want.count, score_bus.aligned_count);
				check_field("rmsd_value", want.rmsd, score_bus.rmsd_value);
				check_field("tm_value", want.tm, score_bus.tm_value);
				check_field("score_status", want.status, score_bus.score_status);
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		residue_t r;
		int sent, chain_len, chain_mode, shape, sh;
		logic signed [CW-1:0] jx, jy, jz;
		logic [D0_W-1:0] set_d0;
		logic [LEN_W-1:0] set_len;
		logic [CUT_W-1:0] set_lo, set_hi;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		residue_bus.valid = 1'b0;
		residue_bus.subj_x = '0;
		residue_bus.subj_y = '0;
		residue_bus.subj_z = '0;
		residue_bus.partner_x = '0;
		residue_bus.partner_y = '0;
		residue_bus.partner_z = '0;
		residue_bus.is_aligned = 1'b0;
		residue_bus.last_residue = 1'b0;
		score_bus.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unaligned words, empty chain, a perfect pair
		add_row(residue_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b1,
			word_of(CLS_UNALIGNED, 0, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(COORD_MAX, 7, -7, COORD_MIN, 0, 1, 1'b0, 1'b1, 1'b1,
			word_of(CLS_UNALIGNED, 0, 1'b1, 0, 0, 0, ST_NO_PAIRS)));
		add_row(residue_row(1000, -2000, 3000, 1000, -2000, 3000, 1'b1, 1'b1, 1'b1,
			word_of(CLS_CLOSE, 0, 1'b1, 1, 0, 655, ST_OK)));
		// each side of both cutoffs
		add_row(residue_row(0, 0, 0, 3071, 0, 0, 1'b1, 1'b0, 1'b1,
			word_of(CLS_CLOSE, 9431041, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(0, 0, 0, -3072, 0, 0, 1'b1, 1'b0, 1'b1,
			word_of(CLS_NEAR, 9437184, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(0, 0, 0, 0, 5119, 0, 1'b1, 1'b0, 1'b1,
			word_of(CLS_NEAR, 26204161, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(0, 0, -5120, 0, 0, 0, 1'b1, 1'b0, 1'b1,
			word_of(CLS_FAR, 26214400, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0, '0));
		// largest coordinate differences, rmsd saturates
		add_row(residue_row(COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0, '0));
		add_row(residue_row(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 1'b0, '0));
		// cutoffs out of order
		add_row(reg_row(REG_CUT_CLOSE, CUT_NEAR_RESET));
		add_row(reg_row(REG_CUT_NEAR, CUT_CLOSE_RESET));
		add_row(residue_row(0, 0, 0, 3072, 0, 0, 1'b1, 1'b0, 1'b1,
			word_of(CLS_NEAR, 9437184, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(0, 0, 0, 0, 0, 5120, 1'b1, 1'b1, 1'b0, '0));
		// zero d0 squared counts as one
		add_row(reg_row(REG_D0_SQ, 0));
		add_row(residue_row(5, 5, 5, 5, 5, 5, 1'b1, 1'b0, 1'b1,
			word_of(CLS_CLOSE, 0, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(5, 5, 5, 6, 5, 5, 1'b1, 1'b1, 1'b0, '0));
		// short target, and no pairs winning over it
		add_row(reg_row(REG_TARGET_LEN, SHORT_TARGET - 1'b1));
		add_row(residue_row(-9, 9, 0, -9, 9, 0, 1'b1, 1'b1, 1'b1,
			word_of(CLS_CLOSE, 0, 1'b1, 1, 0, 0, ST_SHORT)));
		add_row(reg_row(REG_TARGET_LEN, 0));
		add_row(residue_row(1, 2, 3, 4, 5, 6, 1'b0, 1'b1, 1'b1,
			word_of(CLS_UNALIGNED, 0, 1'b1, 0, 0, 0, ST_NO_PAIRS)));
		// register extremes
		add_row(reg_row(REG_D0_SQ, {D0_W{1'b1}}));
		add_row(reg_row(REG_TARGET_LEN, LEN_MAX));
		add_row(reg_row(REG_CUT_CLOSE, 0));
		add_row(reg_row(REG_CUT_NEAR, {CUT_W{1'b1}}));
		add_row(residue_row(77, 77, 77, 77, 77, 77, 1'b1, 1'b0, 1'b1,
			word_of(CLS_NEAR, 0, 1'b0, 0, 0, 0, ST_OK)));
		add_row(residue_row(1234567, -7654321, 42, -3000000, 8000000, -42,
			1'b1, 1'b1, 1'b0, '0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				drain_results(4);
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				deliver(plan[i].res, plan[i].typed, plan[i].want);
			end
		end

		// random phases, each with its own settings and a run of whole chains
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					set_d0 = 1;
					set_len = SHORT_TARGET;
					set_lo = '0;
					set_hi = '0;
				end
				1: begin
					set_d0 = '1;
					set_len = SHORT_TARGET;
					set_lo = '1;
					set_hi = '1;
				end
				2: begin
					set_d0 = '0;
					set_len = LEN_MAX;
					set_lo = pick_cut();
					set_hi = pick_cut();
				end
				default: begin
					case ($urandom_range(0, 3))
						0: set_d0 = '0;
						1: set_d0 = '1;
						2: set_d0 = D0_RESET;
						default: set_d0 = $urandom >> $urandom_range(3, 31);
					endcase
					set_len = ($urandom_range(0, 3) == 0) ? SHORT_TARGET - 1'b1 :
						$urandom_range(0, LEN_MAX);
					set_lo = pick_cut();
					set_hi = pick_cut();
				end
			endcase
			drain_results(4);
			write_reg(REG_D0_SQ, set_d0);
			write_reg(REG_TARGET_LEN, set_len);
			write_reg(REG_CUT_CLOSE, set_lo);
			write_reg(REG_CUT_NEAR, set_hi);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				chain_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48) :
					$urandom_range(1, 16);
				// chain kinds: no pairs, tight pairs only, or a mix
				chain_mode = $urandom_range(0, 9);
				for (int j = 0; j < chain_len; j++) begin
					if (chain_mode == 0)
						r.aligned = 1'b0;
					else if (chain_mode <= 3)
						r.aligned = 1'b1;
					else
						r.aligned = ($urandom_range(0, 4) != 0);
					r.last = (j == chain_len - 1);
					r.sx = $urandom;
					r.sy = $urandom;
					r.sz = $urandom;
					shape = (chain_mode <= 3) ? 2 : $urandom_range(0, 9);
					if (shape == 0) begin
						r.px = $urandom;
						r.py = $urandom;
						r.pz = $urandom;
					end else if (shape == 1) begin
						r.sx = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
						r.sy = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
						r.sz = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
						r.px = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
						r.py = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
						r.pz = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
					end else begin
						// partner near the subject, at a random scale
						sh = (chain_mode <= 3) ? $urandom_range(11, 23) :
							$urandom_range(0, 23);
						jx = $urandom;
						jy = $urandom;
						jz = $urandom;
						r.px = r.sx + (jx >>> sh);
						r.py = r.sy + (jy >>> sh);
						r.pz = r.sz + (jz >>> sh);
					end
					deliver(r, 1'b0, '0);
				end
				sent += chain_len;
			end
		end

		drain_results(200);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
